@@ hw/rtl/msq_pkg.sv @@
// shared types and constants for the multi-stack top-two range query unit
package msq_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int PUSH_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ANS_W    = 16;
    localparam int IDX_SPAN = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH  = 2'd0;
    localparam t_cmd CMD_POP   = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_NONE  = 2'd3;

    typedef struct packed {
        logic clear;
        logic en;
    } t_merge_ctl;

endpackage

@@ hw/rtl/msq_level_ram.sv @@
// level summary memory: one write port, one read port, registered read data
module msq_level_ram #(
    parameter int AW = 10,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/msq_top2_merge.sv @@
// running largest / second-largest merge over the top summaries of a query range
module msq_top2_merge #(
    parameter int VW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msq_pkg::t_merge_ctl i_ctl,
    input  logic [VW-1:0]       i_max,
    input  logic [VW-1:0]       i_sec,
    input  logic                i_sec_ok,
    output logic                o_have1,
    output logic                o_have2,
    output logic [VW-1:0]       o_best1,
    output logic [VW-1:0]       o_best2
);

    logic          r_have1, r_have2;
    logic [VW-1:0] r_best1, r_best2;
    logic          n_have1, n_have2;
    logic [VW-1:0] n_best1, n_best2;

    always_comb begin
        n_have1 = r_have1;
        n_have2 = r_have2;
        n_best1 = r_best1;
        n_best2 = r_best2;
        // stack max first, then its own second against the updated runner-up
        if (!r_have1 || (r_best1 < i_max)) begin
            n_best2 = r_best1;
            n_have2 = r_have1;
            n_best1 = i_max;
            n_have1 = 1'b1;
        end else if (!r_have2 || (r_best2 < i_max)) begin
            n_best2 = i_max;
            n_have2 = 1'b1;
        end
        if (i_sec_ok && (!n_have2 || (n_best2 < i_sec))) begin
            n_best2 = i_sec;
            n_have2 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
            r_best1 <= '0;
            r_best2 <= '0;
        end else if (i_ctl.en) begin
            r_have1 <= n_have1;
            r_have2 <= n_have2;
            r_best1 <= n_best1;
            r_best2 <= n_best2;
        end
    end

    assign o_have1 = r_have1;
    assign o_have2 = r_have2;
    assign o_best1 = r_best1;
    assign o_best2 = r_best2;

endmodule

@@ hw/rtl/multi_stack_top_two_range_query_unit.sv @@
// bank of bounded stacks with per-level top-two summaries and range queries
// push onto a non-empty stack reads the old top level, then writes the new level;
// other pushes, pops, reversed-range queries and other commands go from S_EXEC to S_OUT,
// a query scans in S_QSCAN: one level memory read per non-empty stack in the range
// throughput: one transaction at a time
// reset: synchronous active-low reset empties every stack; the level memory
// is not cleared, only levels below a stack's height are ever read
module multi_stack_top_two_range_query_unit #(
    parameter int NUM_STACKS  = 16,
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [msq_pkg::CMD_W-1:0]     i_command,
    input  logic [msq_pkg::IDX_W-1:0]     i_stack_index,
    input  logic [msq_pkg::PUSH_W-1:0]    i_push_value,
    input  logic [msq_pkg::IDX_W-1:0]     i_range_first,
    input  logic [msq_pkg::IDX_W-1:0]     i_range_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [msq_pkg::STATUS_W-1:0]  o_status,
    output logic [msq_pkg::ANS_W-1:0]     o_answer
);

    // only stacks reachable by a 4-bit index get storage
    localparam int HS = (NUM_STACKS < msq_pkg::IDX_SPAN) ? NUM_STACKS : msq_pkg::IDX_SPAN;
    localparam int SW = (HS > 1) ? $clog2(HS) : 1;
    localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int DW = 2 * VW + 1;
    localparam int AW = SW + LW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH_WB,
        S_QSCAN,
        S_QDRAIN,
        S_QRES,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [HW-1:0] r_heights [HS];

    logic                         r_out_valid;
    msq_pkg::t_status             r_status;
    logic [msq_pkg::ANS_W-1:0]    r_answer;
    msq_pkg::t_status             r_res_status, n_res_status;
    logic [msq_pkg::ANS_W-1:0]    r_res_answer, n_res_answer;

    msq_pkg::t_cmd                r_cmd;
    logic [msq_pkg::IDX_W-1:0]    r_idx;
    logic [VW-1:0]                r_val;
    logic [msq_pkg::IDX_W-1:0]    r_first, r_last;
    logic [msq_pkg::IDX_W-1:0]    r_scan, n_scan;
    logic                         r_pend, n_pend;

    logic                         in_acc;
    logic [31:0]                  push_ext;
    logic [msq_pkg::IDX_W-1:0]    sel_idx;
    logic                         sel_ok;
    logic [HW-1:0]                h_sel, hm1;
    logic                         ht_we;
    logic [HW-1:0]                ht_val;

    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [DW-1:0]                mem_wdata, mem_rdata;
    logic [VW-1:0]                rd_max, rd_sec;
    logic                         rd_ok;
    logic [VW-1:0]                up_max, up_sec;
    logic                         up_ok;

    msq_pkg::t_merge_ctl          mctl;
    logic                         m_have1, m_have2;
    logic [VW-1:0]                m_best1, m_best2;
    logic [31:0]                  best1_ext, best2_ext;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign push_ext   = 32'(i_push_value);

    // one height read port shared by push/pop and the query scan
    assign sel_idx = (r_state == S_QSCAN) ? r_scan : r_idx;
    assign sel_ok  = (5'(sel_idx) < 5'(HS));
    assign h_sel   = r_heights[sel_idx[SW-1:0]];
    assign hm1     = h_sel - 1'b1;

    assign rd_max = mem_rdata[VW-1:0];
    assign rd_sec = mem_rdata[2*VW-1:VW];
    assign rd_ok  = mem_rdata[2*VW];

    // new level from the previous top and the pushed value
    always_comb begin
        up_max = rd_max;
        up_sec = rd_sec;
        up_ok  = rd_ok;
        if (rd_max < r_val) begin
            up_sec = rd_max;
            up_ok  = 1'b1;
            up_max = r_val;
        end else if (!rd_ok || (rd_sec < r_val)) begin
            up_sec = r_val;
            up_ok  = 1'b1;
        end
    end

    assign best1_ext = 32'(m_best1);
    assign best2_ext = 32'(m_best2);

    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_pend       = 1'b0;
        n_res_status = r_res_status;
        n_res_answer = r_res_answer;
        ht_we        = 1'b0;
        ht_val       = h_sel;
        mem_we       = 1'b0;
        mem_waddr    = {sel_idx[SW-1:0], LW'(h_sel)};
        mem_wdata    = {up_ok, up_sec, up_max};
        mem_re       = 1'b0;
        mem_raddr    = {sel_idx[SW-1:0], LW'(hm1)};
        mctl.clear   = 1'b0;
        mctl.en      = r_pend;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = msq_pkg::ST_OK;
                n_res_answer = '0;
                n_state      = S_OUT;
                case (r_cmd)
                    msq_pkg::CMD_PUSH: begin
                        if (!sel_ok || (h_sel == HW'(STACK_DEPTH))) begin
                            n_res_status = msq_pkg::ST_FULL;
                        end else if (h_sel == '0) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b0, {VW{1'b0}}, r_val};
                            ht_we     = 1'b1;
                            ht_val    = h_sel + 1'b1;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_PUSH_WB;
                        end
                    end
                    msq_pkg::CMD_POP: begin
                        if (!sel_ok || (h_sel == '0)) begin
                            n_res_status = msq_pkg::ST_EMPTY;
                        end else begin
                            ht_we  = 1'b1;
                            ht_val = hm1;
                        end
                    end
                    msq_pkg::CMD_QUERY: begin
                        if (r_first > r_last) begin
                            n_res_status = msq_pkg::ST_NONE;
                        end else begin
                            mctl.clear = 1'b1;
                            n_scan     = r_first;
                            n_state    = S_QSCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PUSH_WB: begin
                mem_we  = 1'b1;
                ht_we   = 1'b1;
                ht_val  = h_sel + 1'b1;
                n_state = S_OUT;
            end
            S_QSCAN: begin
                // read issued here is merged in the following cycle
                if (sel_ok && (h_sel != '0)) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                end
                if (r_scan == r_last) begin
                    n_state = S_QDRAIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_QDRAIN: begin
                n_state = S_QRES;
            end
            S_QRES: begin
                if (m_have2) begin
                    n_res_status = msq_pkg::ST_OK;
                    n_res_answer = best2_ext[msq_pkg::ANS_W-1:0];
                end else if (m_have1) begin
                    n_res_status = msq_pkg::ST_OK;
                    n_res_answer = best1_ext[msq_pkg::ANS_W-1:0];
                end else begin
                    n_res_status = msq_pkg::ST_NONE;
                    n_res_answer = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= msq_pkg::ST_OK;
            r_answer    <= '0;
            r_pend      <= 1'b0;
            for (int k = 0; k < HS; k++) begin
                r_heights[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (ht_we) begin
                r_heights[sel_idx[SW-1:0]] <= ht_val;
            end
            if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_status    <= r_res_status;
                r_answer    <= r_res_answer;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_idx   <= i_stack_index;
            r_val   <= push_ext[VW-1:0];
            r_first <= i_range_first;
            r_last  <= i_range_last;
        end
        r_scan       <= n_scan;
        r_res_status <= n_res_status;
        r_res_answer <= n_res_answer;
    end

    msq_level_ram #(
        .AW (AW),
        .DW (DW)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    msq_top2_merge #(
        .VW (VW)
    ) u_top2_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mctl),
        .i_max    (rd_max),
        .i_sec    (rd_sec),
        .i_sec_ok (rd_ok),
        .o_have1  (m_have1),
        .o_have2  (m_have2),
        .o_best1  (m_best1),
        .o_best2  (m_best2)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_answer    = r_answer;

endmodule

@@ tb/tb_multi_stack_top_two_range_query_unit.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the multi-stack top-two range query unit
module tb_multi_stack_top_two_range_query_unit;

    localparam int N_STACKS     = 16;
    localparam int DEPTH        = 64;
    localparam int N_DIRECTED   = 24;
    localparam int N_RANDOM     = 1900;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    // command 3 has no meaning, the unit must answer ok with zero
    localparam msq_pkg::t_cmd CMD_NOP = 2'd3;

    typedef struct packed {
        msq_pkg::t_status          status;
        logic [msq_pkg::ANS_W-1:0] answer;
    } t_outcome;

    typedef struct packed {
        msq_pkg::t_cmd              cmd;
        logic [msq_pkg::IDX_W-1:0]  idx;
        logic [msq_pkg::PUSH_W-1:0] val;
        logic [msq_pkg::IDX_W-1:0]  first;
        logic [msq_pkg::IDX_W-1:0]  last;
        logic                       typed;
        msq_pkg::t_status           status;
        logic [msq_pkg::ANS_W-1:0]  answer;
    } t_op;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [msq_pkg::CMD_W-1:0]    i_command = '0;
    logic [msq_pkg::IDX_W-1:0]    i_stack_index = '0;
    logic [msq_pkg::PUSH_W-1:0]   i_push_value = '0;
    logic [msq_pkg::IDX_W-1:0]    i_range_first = '0;
    logic [msq_pkg::IDX_W-1:0]    i_range_last = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [msq_pkg::STATUS_W-1:0] o_status;
    logic [msq_pkg::ANS_W-1:0]    o_answer;

    multi_stack_top_two_range_query_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_stack_index (i_stack_index),
        .i_push_value  (i_push_value),
        .i_range_first (i_range_first),
        .i_range_last  (i_range_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_answer      (o_answer)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the stack bank
    logic [msq_pkg::PUSH_W-1:0] lvl_max    [N_STACKS][DEPTH];
    logic [msq_pkg::PUSH_W-1:0] lvl_sec    [N_STACKS][DEPTH];
    logic                       lvl_sec_ok [N_STACKS][DEPTH];
    int                         lvl_count  [N_STACKS] = '{default: 0};

    t_outcome pending_outcomes[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    int       phase = 0;
    int       send_idle = 11;
    int       recv_idle = 79;

    // burst state for the random part
    int       burst_left = 0;
    int       burst_stack = 0;
    bit       burst_push = 1'b0;

    // directed table: typed-in outcome where obvious, otherwise the shadow model decides
    t_op directed_ops [N_DIRECTED] = '{
        '{msq_pkg::CMD_POP,   4'd0,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_EMPTY, 16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd0,  4'd15, 1'b1, msq_pkg::ST_NONE,  16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd5,  4'd2,  1'b1, msq_pkg::ST_NONE,  16'h0000},
        '{CMD_NOP,            4'd15, 16'hffff, 4'd15, 4'd15, 1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd0,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd0,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd0,  4'd0,  1'b0, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd15, 16'hffff, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd15, 4'd15, 1'b1, msq_pkg::ST_OK,    16'hffff},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd0,  4'd15, 1'b0, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd15, 16'hffff, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd14, 4'd15, 1'b0, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd7,  16'h5555, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_PUSH,  4'd7,  16'haaaa, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd7,  4'd7,  1'b0, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_POP,   4'd7,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd0,  4'd15, 1'b0, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd15, 4'd0,  1'b1, msq_pkg::ST_NONE,  16'h0000},
        '{msq_pkg::CMD_POP,   4'd15, 16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_POP,   4'd15, 16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000},
        '{msq_pkg::CMD_POP,   4'd15, 16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_EMPTY, 16'h0000},
        '{msq_pkg::CMD_QUERY, 4'd0,  16'h0000, 4'd1,  4'd6,  1'b1, msq_pkg::ST_NONE,  16'h0000},
        '{CMD_NOP,            4'd0,  16'h0000, 4'd0,  4'd0,  1'b1, msq_pkg::ST_OK,    16'h0000}
    };

    // applies one command to the shadow bank and returns what the unit must answer
    function automatic t_outcome stack_bank_outcome(t_op op);
        t_outcome                   res;
        int                         h;
        logic [msq_pkg::PUSH_W-1:0] v_max;
        logic [msq_pkg::PUSH_W-1:0] v_sec;
        logic                       v_ok;
        logic                       have1;
        logic                       have2;
        logic [msq_pkg::PUSH_W-1:0] best1;
        logic [msq_pkg::PUSH_W-1:0] best2;
        logic [msq_pkg::PUSH_W-1:0] m1;
        res = '{status: msq_pkg::ST_OK, answer: '0};
        case (op.cmd)
            msq_pkg::CMD_PUSH: begin
                h = lvl_count[op.idx];
                if (h >= DEPTH) begin
                    res.status = msq_pkg::ST_FULL;
                end else begin
                    if (h == 0) begin
                        v_max = op.val;
                        v_sec = '0;
                        v_ok  = 1'b0;
                    end else begin
                        v_max = lvl_max[op.idx][h-1];
                        v_sec = lvl_sec[op.idx][h-1];
                        v_ok  = lvl_sec_ok[op.idx][h-1];
                        if (v_max < op.val) begin
                            v_sec = v_max;
                            v_ok  = 1'b1;
                            v_max = op.val;
                        end else if (!v_ok || v_sec < op.val) begin
                            // an equal value becomes the second
                            v_sec = op.val;
                            v_ok  = 1'b1;
                        end
                    end
                    lvl_max[op.idx][h]    = v_max;
                    lvl_sec[op.idx][h]    = v_sec;
                    lvl_sec_ok[op.idx][h] = v_ok;
                    lvl_count[op.idx]     = h + 1;
                end
            end
            msq_pkg::CMD_POP: begin
                if (lvl_count[op.idx] == 0) begin
                    res.status = msq_pkg::ST_EMPTY;
                end else begin
                    lvl_count[op.idx]--;
                end
            end
            msq_pkg::CMD_QUERY: begin
                have1 = 1'b0;
                have2 = 1'b0;
                best1 = '0;
                best2 = '0;
                if (op.first <= op.last) begin
                    for (int s = int'(op.first); s <= int'(op.last); s++) begin
                        h = lvl_count[s];
                        if (h != 0) begin
                            m1 = lvl_max[s][h-1];
                            if (!have1 || best1 < m1) begin
                                best2 = best1;
                                have2 = have1;
                                best1 = m1;
                                have1 = 1'b1;
                            end else if (!have2 || best2 < m1) begin
                                best2 = m1;
                                have2 = 1'b1;
                            end
                            if (lvl_sec_ok[s][h-1] && (!have2 || best2 < lvl_sec[s][h-1])) begin
                                best2 = lvl_sec[s][h-1];
                                have2 = 1'b1;
                            end
                        end
                    end
                end
                if (have2) begin
                    res.answer = best2;
                end else if (have1) begin
                    res.answer = best1;
                end else begin
                    res.status = msq_pkg::ST_NONE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // push/pop bursts on one stack so stacks fill and drain, with queries mixed in, between random single commands
    function automatic t_op random_op();
        t_op r;
        int  pick;
        logic [msq_pkg::IDX_W-1:0] tmp;
        r = '0;
        r.idx   = msq_pkg::IDX_W'($urandom_range(0, N_STACKS - 1));
        r.first = msq_pkg::IDX_W'($urandom_range(0, msq_pkg::IDX_SPAN - 1));
        r.last  = msq_pkg::IDX_W'($urandom_range(0, msq_pkg::IDX_SPAN - 1));
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
            r.val = msq_pkg::PUSH_W'($urandom_range(0, 7));
        end else if (pick == 2) begin
            r.val = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end else begin
            r.val = msq_pkg::PUSH_W'($urandom_range(0, 65535));
        end
        if (burst_left == 0 && $urandom_range(0, 999) < 15) begin
            burst_left  = $urandom_range(20, 90);
            burst_stack = $urandom_range(0, N_STACKS - 1);
            burst_push  = ($urandom_range(0, 2) != 0);
        end
        if (burst_left > 0) begin
            burst_left--;
            if ($urandom_range(0, 3) == 0) begin
                r.cmd = msq_pkg::CMD_QUERY;
            end else begin
                r.cmd = burst_push ? msq_pkg::CMD_PUSH : msq_pkg::CMD_POP;
                r.idx = msq_pkg::IDX_W'(burst_stack);
            end
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) r.cmd = msq_pkg::CMD_PUSH;
            else if (pick < 60) r.cmd = msq_pkg::CMD_POP;
            else if (pick < 95) r.cmd = msq_pkg::CMD_QUERY;
            else r.cmd = CMD_NOP;
        end
        // most queries get an ordered range, a few stay reversed
        if (r.cmd == msq_pkg::CMD_QUERY && r.first > r.last && $urandom_range(0, 9) != 0) begin
            tmp     = r.first;
            r.first = r.last;
            r.last  = tmp;
        end
        return r;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_stack_top_two_range_query_unit regression: fail");
            $finish;
        end
    end

    // sender
    initial begin
        t_op      op;
        t_outcome want;
        do @(posedge i_clk); while (!i_rst_n);
        for (int n = 0; n < N_DIRECTED + N_RANDOM; n++) begin
            if (n == N_DIRECTED + N_RANDOM / 3) begin
                phase = 1;
                send_idle = 79;
                recv_idle = 11;
            end else if (n == N_DIRECTED + 2 * N_RANDOM / 3) begin
                phase = 2;
                send_idle = 0;
                recv_idle = 0;
            end
            op = (n < N_DIRECTED) ? directed_ops[n] : random_op();
            if ($urandom_range(0, 99) < send_idle) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
            end
            i_in_valid    <= 1'b1;
            i_command     <= op.cmd;
            i_stack_index <= op.idx;
            i_push_value  <= op.val;
            i_range_first <= op.first;
            i_range_last  <= op.last;
            do @(posedge i_clk); while (!o_in_ready);
            want = stack_bank_outcome(op);
            if (op.typed) begin
                want = '{status: op.status, answer: op.answer};
            end
            pending_outcomes.push_back(want);
        end
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multi_stack_top_two_range_query_unit regression: pass");
        end else begin
            $display("multi_stack_top_two_range_query_unit regression: fail");
        end
        $finish;
    end

    // receiver, with one long hold-off once the no-idle phase begins
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (phase == 2 && !held) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result transaction: status %0d answer %0d",
                       o_status, o_answer);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_answer !== want.answer) begin
                    $error("answer mismatch: expected %0d actual %0d", want.answer, o_answer);
                    fail_count++;
                end
            end
        end
    end

endmodule
